### design/u2u_pkg.sv
// Shared types and constants of the UTF-16 to UTF-8 stream transcoder.
package u2u_pkg;

    // Code point width, enough for the supplementary planes.
    localparam int unsigned CP_W = 21;

    // Top six bits of a code unit that mark the two surrogate halves.
    localparam logic [5:0] HIGH_SURR_TAG = 6'h36;
    localparam logic [5:0] LOW_SURR_TAG  = 6'h37;

    // Offset added to a joined surrogate pair.
    localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

    // Bounds of the encoding lengths.
    localparam logic [CP_W-1:0] LIMIT_1 = 21'h80;
    localparam logic [CP_W-1:0] LIMIT_2 = 21'h800;
    localparam logic [CP_W-1:0] LIMIT_3 = 21'h10000;

    // ASCII lowercase range and case offset.
    localparam logic [CP_W-1:0] LOWER_A    = 21'h61;
    localparam logic [CP_W-1:0] LOWER_Z    = 21'h7A;
    localparam logic [CP_W-1:0] CASE_SHIFT = 21'd32;

    // Byte prefixes of UTF-8.
    localparam logic [7:0] LEAD_2 = 8'hC0;
    localparam logic [7:0] LEAD_3 = 8'hE0;
    localparam logic [7:0] LEAD_4 = 8'hF0;
    localparam logic [7:0] CONT   = 8'h80;

    // Sequence length codes: number of bytes minus one.
    localparam logic [1:0] LEN_1 = 2'd0;
    localparam logic [1:0] LEN_2 = 2'd1;
    localparam logic [1:0] LEN_3 = 2'd2;
    localparam logic [1:0] LEN_4 = 2'd3;

    // Configuration register address.
    localparam logic REG_CAPITALIZE = 1'b0;

    // One classified code point waiting to be serialized.
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic [1:0]      len;
        logic            eos;
    } t_q_entry;

endpackage

### design/u2u_front.sv
// Front end: accepts code units, pairs surrogates and classifies the code point.
module u2u_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [15:0]        i_unit,
    input  logic               i_capitalize,
    input  logic               i_q_ready,
    output logic               o_ready,
    output logic               o_push,
    output u2u_pkg::t_q_entry  o_entry
);

    logic       r_pend;
    logic       n_pend;
    logic [9:0] r_pend_bits;
    logic       is_high;
    logic       is_low;
    logic       joined;
    logic       hold;
    logic       accept;
    logic [u2u_pkg::CP_W-1:0] cp_pair;
    logic [u2u_pkg::CP_W-1:0] cp_raw;
    logic [u2u_pkg::CP_W-1:0] cp;

    // Classify the unit and build the code point.
    always_comb begin
        is_high = (i_unit[15:10] == u2u_pkg::HIGH_SURR_TAG);
        is_low  = (i_unit[15:10] == u2u_pkg::LOW_SURR_TAG);
        joined  = r_pend && is_low;
        hold    = !r_pend && is_high;
        cp_pair = {1'b0, r_pend_bits, i_unit[9:0]} + u2u_pkg::SUPP_BASE;
        cp_raw  = joined ? cp_pair : {5'b0, i_unit};
        cp      = cp_raw;
        if (i_capitalize && cp_raw >= u2u_pkg::LOWER_A && cp_raw <= u2u_pkg::LOWER_Z) begin
            cp = cp_raw - u2u_pkg::CASE_SHIFT;
        end
    end

    // Sequence length from the code point range.
    always_comb begin
        o_entry.cp  = cp;
        o_entry.eos = (cp_raw == '0);
        if (cp_raw < u2u_pkg::LIMIT_1) begin
            o_entry.len = u2u_pkg::LEN_1;
        end else if (cp_raw < u2u_pkg::LIMIT_2) begin
            o_entry.len = u2u_pkg::LEN_2;
        end else if (cp_raw < u2u_pkg::LIMIT_3) begin
            o_entry.len = u2u_pkg::LEN_3;
        end else begin
            o_entry.len = u2u_pkg::LEN_4;
        end
    end

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;
    assign o_push  = accept && !hold;

    // A high surrogate met with nothing held is kept; any other unit clears it.
    always_comb begin
        n_pend = r_pend;
        if (accept) begin
            n_pend = hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && hold) begin
            r_pend_bits <= i_unit[9:0];
        end
    end

endmodule

### design/u2u_queue.sv
// Two-entry queue between the front end and the byte serializer.
module u2u_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  u2u_pkg::t_q_entry  i_entry,
    input  logic               i_pop,
    output logic               o_ready,
    output logic               o_valid,
    output u2u_pkg::t_q_entry  o_head
);

    u2u_pkg::t_q_entry r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_slot[r_rptr];

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_entry;
        end
    end

endmodule

### design/u2u_back.sv
// Back end: turns each queued code point into UTF-8 bytes, one word per cycle unless stalled.
module u2u_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  u2u_pkg::t_q_entry  i_head,
    input  logic               i_m_tready,
    output logic               o_pop,
    output logic               o_m_tvalid,
    output logic [7:0]         o_m_tdata,
    output logic               o_m_tlast,
    output logic               o_m_tuser
);

    logic [1:0] r_idx;
    logic [1:0] n_idx;
    logic       r_valid;
    logic [7:0] r_data;
    logic       r_last;
    logic       r_eos;
    logic       load;
    logic       last;
    logic [1:0] grp;
    logic [5:0] bits6;
    logic [7:0] byte_val;

    // Output register is free when empty or being taken.
    assign load  = i_q_valid && (!r_valid || i_m_tready);
    assign last  = (r_idx == i_head.len);
    assign o_pop = load && last;

    // Select the byte at the current position of the sequence.
    always_comb begin
        grp = i_head.len - r_idx;
        case (grp)
            2'd0:    bits6 = i_head.cp[5:0];
            2'd1:    bits6 = i_head.cp[11:6];
            2'd2:    bits6 = i_head.cp[17:12];
            2'd3:    bits6 = {3'b0, i_head.cp[20:18]};
            default: bits6 = i_head.cp[5:0];
        endcase
        if (r_idx != 2'd0) begin
            byte_val = u2u_pkg::CONT | {2'b0, bits6};
        end else begin
            case (i_head.len)
                u2u_pkg::LEN_1: byte_val = {1'b0, i_head.cp[6:0]};
                u2u_pkg::LEN_2: byte_val = u2u_pkg::LEAD_2 | {3'b0, i_head.cp[10:6]};
                u2u_pkg::LEN_3: byte_val = u2u_pkg::LEAD_3 | {4'b0, i_head.cp[15:12]};
                u2u_pkg::LEN_4: byte_val = u2u_pkg::LEAD_4 | {5'b0, i_head.cp[20:18]};
                default:        byte_val = {1'b0, i_head.cp[6:0]};
            endcase
        end
    end

    // Byte position within the sequence.
    always_comb begin
        n_idx = r_idx;
        if (load) begin
            n_idx = last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= byte_val;
            r_last <= last;
            r_eos  <= i_head.eos;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tlast  = r_last;
    assign o_m_tuser  = r_eos;

endmodule

### design/utf16_to_utf8_stream.sv
// Top level of the UTF-16 to UTF-8 stream transcoder.
//
// Usage: code units enter on the s_ stream (one 16-bit unit per word) and the
// UTF-8 bytes leave on the m_ stream, one byte per word. m_tlast marks the last
// byte caused by one input unit, m_tuser marks the terminating zero byte.
// A high surrogate produces no bytes; the unit after it either completes the
// pair (four bytes) or drops it and is encoded alone.
// With the queue empty and the output free, an accepted unit is written into
// a queue entry, and its first byte is then registered in the output word.
// Throughput: while the receiver takes every byte, the serializer emits one
// byte per cycle, so a unit holds it for its whole UTF-8 sequence of one to
// four bytes; one-byte units stream at one per cycle. A two-entry queue lets
// the input keep flowing while the output drains a longer sequence.
// Reset (synchronous, active low) empties the queue and the output register,
// drops any held surrogate and clears capitalize.
// When the receiver stalls, the output word holds and the queue fills; s_tready
// falls once both queue entries are occupied. capitalize lies at APB address 0;
// the user writes it only while the block is idle; the block does not check.
module utf16_to_utf8_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] code_unit
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // last_of_run
    output logic        m_tuser    // [0] end_of_string
);

    logic              r_capitalize;
    logic              q_ready;
    logic              q_valid;
    logic              push;
    logic              pop;
    u2u_pkg::t_q_entry entry;
    u2u_pkg::t_q_entry head;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr == u2u_pkg::REG_CAPITALIZE) ? {31'b0, r_capitalize} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capitalize <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && paddr == u2u_pkg::REG_CAPITALIZE) begin
            r_capitalize <= pwdata[0];
        end
    end

    u2u_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_tvalid),
        .i_unit       (s_tdata),
        .i_capitalize (r_capitalize),
        .i_q_ready    (q_ready),
        .o_ready      (s_tready),
        .o_push       (push),
        .o_entry      (entry)
    );

    u2u_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_head  (head)
    );

    u2u_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_head     (head),
        .i_m_tready (m_tready),
        .o_pop      (pop),
        .o_m_tvalid (m_tvalid),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

endmodule

### design/u2u_checker.sv
// Port-level checker of the transcoder, bound to the top level.
module u2u_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // Reset leaves no byte on the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("output valid right after reset");

    // A stalled byte holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output word changed");

    // The terminating byte is zero and closes its run.
    a_eos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser |-> m_tlast && m_tdata == 8'h00)
        else $error("end of string on a nonzero or non-final byte");

    // A lead byte of a multi-byte sequence never ends a run.
    a_lead_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[7:6] == 2'b11 |-> !m_tlast)
        else $error("lead byte marked last");

    // After a byte that does not end its run, the next byte is a continuation.
    a_cont_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tready && !m_tlast |=> !m_tvalid || m_tdata[7:6] == 2'b10)
        else $error("sequence broken before its last byte");

endmodule

bind utf16_to_utf8_stream u2u_checker u_u2u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

### test/utf16_to_utf8_stream_checker.sv
// Scoreboard for the UTF-16 to UTF-8 stream transcoder: predicts and checks the output bytes.
module utf16_to_utf8_stream_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration, watched for writes
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    // Input stream
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] code_unit
    // Output stream
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] out_byte
    input  logic        m_tlast,   // last_of_run
    input  logic        m_tuser,   // [0] end_of_string
    // Status for the test top
    output int          o_fail_count,
    output int          o_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    // One UTF-8 byte as it should appear on the output stream.
    typedef struct packed {
        logic [7:0] octet;
        logic       last;
        logic       eos;
    } t_utf8_word;

    t_utf8_word      utf8_due[$];
    logic            caps;
    logic            held_high;
    logic [9:0]      held_bits;

    function automatic void push_byte(input logic [7:0] octet, input logic last,
                                      input logic eos);
        t_utf8_word w;
        w.octet = octet;
        w.last  = last;
        w.eos   = eos;
        utf8_due.push_back(w);
    endfunction

    // Turn one code unit into the bytes it should produce, tracking a held
    // high surrogate across units.
    function automatic void encode_unit(input logic [15:0] unit);
        logic [u2u_pkg::CP_W-1:0] cp;
        logic [u2u_pkg::CP_W-1:0] folded;
        logic                     emit;
        cp   = {5'd0, unit};
        emit = 1'b1;
        if (held_high) begin
            held_high = 1'b0;
            if (unit[15:10] == u2u_pkg::LOW_SURR_TAG)
                cp = ({1'b0, held_bits, unit[9:0]}) + u2u_pkg::SUPP_BASE;
            held_bits = '0;
        end else if (unit[15:10] == u2u_pkg::HIGH_SURR_TAG) begin
            held_high = 1'b1;
            held_bits = unit[9:0];
            emit      = 1'b0;
        end
        if (emit) begin
            if (cp < u2u_pkg::LIMIT_1) begin
                folded = cp;
                if (caps && cp >= u2u_pkg::LOWER_A && cp <= u2u_pkg::LOWER_Z)
                    folded = cp - u2u_pkg::CASE_SHIFT;
                push_byte(folded[7:0], 1'b1, cp == '0);
            end else if (cp < u2u_pkg::LIMIT_2) begin
                push_byte(u2u_pkg::LEAD_2 | {3'd0, cp[10:6]}, 1'b0, 1'b0);
                push_byte(u2u_pkg::CONT | {2'd0, cp[5:0]}, 1'b1, 1'b0);
            end else if (cp < u2u_pkg::LIMIT_3) begin
                push_byte(u2u_pkg::LEAD_3 | {4'd0, cp[15:12]}, 1'b0, 1'b0);
                push_byte(u2u_pkg::CONT | {2'd0, cp[11:6]}, 1'b0, 1'b0);
                push_byte(u2u_pkg::CONT | {2'd0, cp[5:0]}, 1'b1, 1'b0);
            end else begin
                push_byte(u2u_pkg::LEAD_4 | {5'd0, cp[20:18]}, 1'b0, 1'b0);
                push_byte(u2u_pkg::CONT | {2'd0, cp[17:12]}, 1'b0, 1'b0);
                push_byte(u2u_pkg::CONT | {2'd0, cp[11:6]}, 1'b0, 1'b0);
                push_byte(u2u_pkg::CONT | {2'd0, cp[5:0]}, 1'b1, 1'b0);
            end
        end
    endfunction

    // Output words are checked before the input word of the same edge is
    // predicted, so a byte can never be matched against its own input.
    always @(posedge i_clk) begin
        t_utf8_word want;
        if (!i_rst_n) begin
            caps      = 1'b0;
            held_high = 1'b0;
            held_bits = '0;
            utf8_due.delete();
        end else begin
            if (m_tvalid === 1'b1 && m_tready) begin
                if (utf8_due.size() == 0) begin
                    $error("out_byte: unexpected word %02h", m_tdata);
                    o_fail_count++;
                end else begin
                    want = utf8_due.pop_front();
                    if (m_tdata !== want.octet) begin
                        $error("out_byte: expected %02h, got %02h", want.octet, m_tdata);
                        o_fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_of_run: expected %0b, got %0b", want.last, m_tlast);
                        o_fail_count++;
                    end
                    if (m_tuser !== want.eos) begin
                        $error("end_of_string: expected %0b, got %0b", want.eos, m_tuser);
                        o_fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready === 1'b1)
                encode_unit(s_tdata);
            if (psel && penable && pwrite && pready && paddr == u2u_pkg::REG_CAPITALIZE)
                caps = pwdata[0];
        end
        o_waiting = utf8_due.size();
    end

endmodule

### test/utf16_to_utf8_stream_tb.sv
// Test top of the UTF-16 to UTF-8 stream transcoder: stimulus, flow control and verdict.
module utf16_to_utf8_stream_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RANDOM_UNITS = 68;      // per random phase
    localparam int  DRAIN_CYCLES = 8;
    localparam int  HOLD_CYCLES  = 120;
    localparam int  TIMEOUT_NS   = 1_000_000;

    // Extremes of each encoding length, surrogate corner cases and string ends.
    localparam logic [15:0] DIRECTED_UNITS [24] = '{
        16'h0061, 16'h007A, 16'h0060, 16'h007B, 16'h0041, 16'h007F,
        16'h0080, 16'h07FF, 16'h0800, 16'hFFFF,
        16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF,
        16'hDC00,
        16'hD800, 16'hDBFF, 16'hDFFF,
        16'hD834, 16'h0000,
        16'h0001,
        16'hD83D, 16'h0041, 16'h0000
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic        paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    int          fail_count;
    int          bytes_waiting;
    int          burst_left;
    logic        hold_armed;

    utf16_to_utf8_stream dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    utf16_to_utf8_stream_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser),
        .o_fail_count (fail_count),
        .o_waiting    (bytes_waiting)
    );

    // 10 ns clock.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Offer one code unit and hold it until accepted; bursts of random
    // length are separated by random gaps.
    task automatic send_unit(input logic [15:0] unit);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= unit;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        burst_left--;
    endtask

    // Register write with a setup phase and an access phase held until pready.
    task automatic apb_write(input logic addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stop offering, wait for every predicted byte, then let a held
    // surrogate or anything in flight settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (bytes_waiting != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly well-formed text: plenty of surrogate pairs, with broken pairs,
    // stray halves, terminators and raw noise mixed in.
    task automatic send_random_units(input int count);
        int          sent;
        int          pick;
        logic [15:0] unit;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                send_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
                send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
                sent += 2;
            end else if (pick < 38) begin
                send_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
                do unit = 16'($urandom); while (unit[15:10] == u2u_pkg::LOW_SURR_TAG);
                send_unit(unit);
                sent += 2;
            end else begin
                if (pick < 55) begin
                    unit = 16'($urandom_range(1, 16'h7F));
                end else if (pick < 63) begin
                    unit = 16'($urandom_range(16'h61, 16'h7A));
                end else if (pick < 71) begin
                    unit = 16'($urandom_range(16'h80, 16'h7FF));
                end else if (pick < 79) begin
                    do unit = 16'($urandom_range(16'h800, 16'hFFFF));
                    while (unit[15:11] == 5'b11011);
                end else if (pick < 84) begin
                    unit = 16'($urandom_range(16'hDC00, 16'hDFFF));
                end else if (pick < 88) begin
                    unit = '0;
                end else begin
                    unit = 16'($urandom);
                end
                send_unit(unit);
                sent++;
            end
        end
    endtask

    // Receiver: stretches of free flow, random stalls and a sparse pattern,
    // plus one long hold-off once the random traffic has started.
    initial begin
        int  mode;
        int  stretch;
        bit  hold_done;
        hold_done = 1'b0;
        forever begin
            if (hold_armed && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(10, 50);
            for (int k = 0; k < stretch; k++) begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= (k % 3 == 0);
                    default: m_tready <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        hold_armed = 1'b0;
        burst_left = 0;
        i_rst_n  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= u2u_pkg::REG_CAPITALIZE;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed units with upper-casing on.
        apb_write(u2u_pkg::REG_CAPITALIZE, 32'd1);
        foreach (DIRECTED_UNITS[i])
            send_unit(DIRECTED_UNITS[i]);
        wait_idle();

        // Random traffic with upper-casing off, including the long stall.
        apb_write(u2u_pkg::REG_CAPITALIZE, 32'd0);
        hold_armed = 1'b1;
        send_random_units(RANDOM_UNITS);
        wait_idle();

        // Random traffic with upper-casing back on.
        apb_write(u2u_pkg::REG_CAPITALIZE, 32'd1);
        send_random_units(RANDOM_UNITS);
        wait_idle();

        if (fail_count == 0) begin
            $display("utf16_to_utf8_stream_tb passed");
        end else begin
            $display("utf16_to_utf8_stream_tb failed");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #(TIMEOUT_NS);
        $display("utf16_to_utf8_stream_tb failed");
        $finish;
    end

endmodule

### utf16_to_utf8_stream.f
design/u2u_pkg.sv
design/u2u_front.sv
design/u2u_queue.sv
design/u2u_back.sv
design/utf16_to_utf8_stream.sv
design/u2u_checker.sv
test/utf16_to_utf8_stream_checker.sv
test/utf16_to_utf8_stream_tb.sv
